// ===== rtl/core/dps_pkg.sv =====
package dps_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_G_OVER_L  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANG = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_VEL = 3'd6;

  // Q30 angle constants
  localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [34:0] Q30_TWO_PI  = 35'sd6746518852;
  localparam logic signed [33:0] Q30_GAIN    = 34'sd652032874;
  localparam int ATAN_ENTRIES = 24;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 67;

  typedef enum logic [1:0] {
    SH_Q30  = 2'd0,
    SH_FRAC = 2'd1,
    SH_DAMP = 2'd2
  } shift_sel_t;

  typedef struct packed {
    logic                    start;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
    logic signed [MUL_W-1:0] addend;
    logic                    negate;
    shift_sel_t              shift_sel;
  } mul_req_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'h3243F6A8;
      5'd1:  v = 30'h1DAC6705;
      5'd2:  v = 30'h0FADBAFC;
      5'd3:  v = 30'h07F56EA6;
      5'd4:  v = 30'h03FEAB76;
      5'd5:  v = 30'h01FFD55B;
      5'd6:  v = 30'h00FFFAAA;
      5'd7:  v = 30'h007FFF55;
      5'd8:  v = 30'h003FFFEA;
      5'd9:  v = 30'h001FFFFD;
      5'd10: v = 30'h000FFFFF;
      5'd11: v = 30'h0007FFFF;
      5'd12: v = 30'h0003FFFF;
      5'd13: v = 30'h0001FFFF;
      5'd14: v = 30'h0000FFFF;
      5'd15: v = 30'h00007FFF;
      5'd16: v = 30'h00003FFF;
      5'd17: v = 30'h00001FFF;
      5'd18: v = 30'h00000FFF;
      5'd19: v = 30'h000007FF;
      5'd20: v = 30'h000003FF;
      5'd21: v = 30'h000001FF;
      5'd22: v = 30'h000000FF;
      5'd23: v = 30'h0000007F;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/dps_if.sv =====
interface dps_in_if;
  logic        valid;
  logic        ready;
  logic [16:0] time_step;
  logic        restart;
  modport source (output valid, time_step, restart, input ready);
  modport sink (input valid, time_step, restart, output ready);
endinterface

interface dps_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle_out;
  logic signed [31:0] velocity_out;
  logic signed [31:0] acceleration_out;
  logic signed [31:0] bob_x;
  logic signed [31:0] bob_y;
  modport source (output valid, angle_out, velocity_out, acceleration_out, bob_x, bob_y,
                  input ready);
  modport sink (input valid, angle_out, velocity_out, acceleration_out, bob_x, bob_y,
                output ready);
endinterface

// ===== rtl/core/damped_pendulum_step_unit.sv =====
// Channel     | Dir | Transfer when      | Payload
// item_in     | in  | valid && ready     | time_step[16:0], restart
// result_out  | out | valid && ready     | angle_out, velocity_out, acceleration_out,
//             |     |                    | bob_x, bob_y (signed Q16.16)
// cfg         | in  | cfg_we             | cfg_index[2:0], cfg_wdata[31:0]
//
// One tick takes two sine/cosine evaluations plus six multiply passes:
//   each CORDIC call is an issue, the range reduction, a fold, the rotations and a capture;
//   each multiply is an issue and the two multiplier stages; a tick also has an accept
//   and an output load.
// Every step waits on the single CORDIC unit or the single two-stage multiplier.
// A finished result sits in the output register; the next tick is taken meanwhile,
// and its own result waits in S_OUT until the output register frees up.
// Synchronous active-high reset loads register and state defaults.
module damped_pendulum_step_unit #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  dps_in_if.sink                         item_in,
  dps_out_if.source                      result_out
);
  import dps_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_SC1  = 10'b0000000010,
    S_ACC  = 10'b0000000100,
    S_V1   = 10'b0000001000,
    S_V2   = 10'b0000010000,
    S_ANG  = 10'b0000100000,
    S_SC2  = 10'b0001000000,
    S_BX   = 10'b0010000000,
    S_BY   = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  // configuration registers
  logic [30:0]        pendulum_length;
  logic [30:0]        gravity_over_length;
  logic [15:0]        damping_factor;
  logic signed [31:0] pivot_x;
  logic signed [31:0] pivot_y;
  logic signed [31:0] start_angle;
  logic signed [31:0] start_velocity;

  // pendulum state and per-tick scratch
  state_t             state;
  logic               pend;
  logic signed [31:0] angle;
  logic signed [31:0] velocity;
  logic signed [31:0] accel;
  logic signed [31:0] sin_v;
  logic signed [31:0] cos_v;
  logic signed [31:0] bx;
  logic signed [31:0] by;
  logic [16:0]        dt;
  logic               out_valid;

  mul_req_t           mreq;
  logic               mul_done;
  logic signed [31:0] mul_result;
  logic               cordic_start;
  logic               cordic_done;
  logic signed [31:0] cordic_sin;
  logic signed [31:0] cordic_cos;

  assign item_in.ready    = (state == S_IDLE);
  assign result_out.valid = out_valid;

  // Register writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      pendulum_length     <= 31'd32768;
      gravity_over_length <= 31'd1285816;
      damping_factor      <= 16'd64881;
      pivot_x             <= '0;
      pivot_y             <= '0;
      start_angle         <= 32'sd262144;
      start_velocity      <= 32'sd6554;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LENGTH:    pendulum_length     <= cfg_wdata[30:0];
        REG_G_OVER_L:  gravity_over_length <= cfg_wdata[30:0];
        REG_DAMPING:   damping_factor      <= cfg_wdata[15:0];
        REG_PIVOT_X:   pivot_x             <= cfg_wdata;
        REG_PIVOT_Y:   pivot_y             <= cfg_wdata;
        REG_START_ANG: start_angle         <= cfg_wdata;
        REG_START_VEL: start_velocity      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Route operands of each step to the shared multiplier
  always_comb begin
    mreq           = '0;
    mreq.start     = !pend && (state == S_ACC || state == S_V1 || state == S_V2 ||
                               state == S_ANG || state == S_BX || state == S_BY);
    mreq.shift_sel = SH_Q30;
    case (state)
      S_ACC: begin
        // acc = -(g/L * sin)
        mreq.a      = $signed({2'b0, gravity_over_length});
        mreq.b      = MUL_W'(sin_v);
        mreq.negate = 1'b1;
      end
      S_V1: begin
        mreq.a         = MUL_W'(accel);
        mreq.b         = $signed({16'b0, dt});
        mreq.addend    = MUL_W'(velocity);
        mreq.shift_sel = SH_FRAC;
      end
      S_V2: begin
        mreq.a         = MUL_W'(velocity);
        mreq.b         = $signed({17'b0, damping_factor});
        mreq.shift_sel = SH_DAMP;
      end
      S_ANG: begin
        mreq.a         = MUL_W'(velocity);
        mreq.b         = $signed({16'b0, dt});
        mreq.addend    = MUL_W'(angle);
        mreq.shift_sel = SH_FRAC;
      end
      S_BX: begin
        mreq.a      = $signed({2'b0, pendulum_length});
        mreq.b      = MUL_W'(sin_v);
        mreq.addend = MUL_W'(pivot_x);
      end
      S_BY: begin
        mreq.a      = $signed({2'b0, pendulum_length});
        mreq.b      = MUL_W'(cos_v);
        mreq.addend = MUL_W'(pivot_y);
      end
      default: ;
    endcase
  end

  assign cordic_start = !pend && (state == S_SC1 || state == S_SC2);

  // Sequencer: each step issues once, then waits for its unit to finish
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      angle     <= 32'sd262144;
      velocity  <= 32'sd6554;
      out_valid <= 1'b0;
    end else begin
      // drop valid after the transfer unless S_OUT reloads the register this cycle
      if (result_out.valid && result_out.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      if (mreq.start || cordic_start) begin
        pend <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (item_in.valid) begin
            dt <= item_in.time_step;
            if (item_in.restart) begin
              angle    <= start_angle;
              velocity <= start_velocity;
            end
            state <= S_SC1;
          end
        end
        S_SC1: begin
          if (cordic_done) begin
            sin_v <= cordic_sin;
            pend  <= 1'b0;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (mul_done) begin
            accel <= mul_result;
            pend  <= 1'b0;
            state <= S_V1;
          end
        end
        S_V1: begin
          if (mul_done) begin
            velocity <= mul_result;
            pend     <= 1'b0;
            state    <= S_V2;
          end
        end
        S_V2: begin
          if (mul_done) begin
            velocity <= mul_result;
            pend     <= 1'b0;
            state    <= S_ANG;
          end
        end
        S_ANG: begin
          if (mul_done) begin
            angle <= mul_result;
            pend  <= 1'b0;
            state <= S_SC2;
          end
        end
        S_SC2: begin
          if (cordic_done) begin
            sin_v <= cordic_sin;
            cos_v <= cordic_cos;
            pend  <= 1'b0;
            state <= S_BX;
          end
        end
        S_BX: begin
          if (mul_done) begin
            bx    <= mul_result;
            pend  <= 1'b0;
            state <= S_BY;
          end
        end
        S_BY: begin
          if (mul_done) begin
            by    <= mul_result;
            pend  <= 1'b0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid || result_out.ready) begin
            result_out.angle_out        <= angle;
            result_out.velocity_out     <= velocity;
            result_out.acceleration_out <= accel;
            result_out.bob_x            <= bx;
            result_out.bob_y            <= by;
            out_valid                   <= 1'b1;
            state                       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  dps_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .req    (mreq),
    .done   (mul_done),
    .result (mul_result)
  );

  dps_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .angle   (angle),
    .done    (cordic_done),
    .sin_q30 (cordic_sin),
    .cos_q30 (cordic_cos)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_in.valid && item_in.ready |=> !item_in.ready)
    else $error("input taken again while a tick is in flight");

  a_cordic_done_expected: assert property (@(posedge clk) disable iff (rst)
    cordic_done |-> pend && (state == S_SC1 || state == S_SC2))
    else $error("cordic finished outside a sine step");

  a_mul_done_expected: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> pend && (state == S_ACC || state == S_V1 || state == S_V2 ||
                          state == S_ANG || state == S_BX || state == S_BY))
    else $error("multiplier finished outside a multiply step");

endmodule

// ===== rtl/core/dps_mul.sv =====
module dps_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  dps_pkg::mul_req_t  req,
  output logic               done,
  output logic signed [31:0] result
);
  import dps_pkg::*;

  logic                     v1;
  logic signed [PROD_W-1:0] prod;
  logic signed [MUL_W-1:0]  addend;
  logic                     negate;
  shift_sel_t               shift_sel;

  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] shifted;
  logic signed [PROD_W-1:0] sum;

  // Stage one: product; addend, negate and shift select are registered alongside
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= req.start;
    end
    if (req.start) begin
      prod      <= PROD_W'(req.a * req.b);
      addend    <= req.addend;
      negate    <= req.negate;
      shift_sel <= req.shift_sel;
    end
  end

  // Stage two: round half up, shift, optional negate, add, saturate
  always_comb begin
    case (shift_sel)
      SH_Q30: begin
        rnd     = prod + (PROD_W'(1) <<< 29);
        shifted = rnd >>> 30;
      end
      SH_FRAC: begin
        rnd     = prod + (PROD_W'(1) <<< (FRAC_BITS - 1));
        shifted = rnd >>> FRAC_BITS;
      end
      SH_DAMP: begin
        rnd     = prod + (PROD_W'(1) <<< 15);
        shifted = rnd >>> 16;
      end
      default: begin
        rnd     = prod;
        shifted = prod;
      end
    endcase
    sum = (negate ? -shifted : shifted) + PROD_W'(addend);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v1;
    end
    if (v1) begin
      if (sum > PROD_W'(64'sh7FFF_FFFF)) begin
        result <= 32'sh7FFF_FFFF;
      end else if (sum < -PROD_W'(64'sh8000_0000)) begin
        result <= 32'sh8000_0000;
      end else begin
        result <= sum[31:0];
      end
    end
  end

  a_no_stray_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(req.start, 2))
    else $error("multiplier result without request");

endmodule

// ===== rtl/core/dps_cordic.sv =====
module dps_cordic #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] angle,
  output logic               done,
  output logic signed [31:0] sin_q30,
  output logic signed [31:0] cos_q30
);
  import dps_pkg::*;

  localparam int RW   = 64 - FRAC_BITS;
  localparam int KMAX = 30 - FRAC_BITS;
  localparam int NS   = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam logic [RW-1:0] RED_OFS = RW'(Q30_TWO_PI) << (29 - FRAC_BITS);
  localparam logic [RW-1:0] MOD_TOP = RW'(Q30_TWO_PI) << KMAX;

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_RED  = 4'b0010,
    C_FOLD = 4'b0100,
    C_ROT  = 4'b1000
  } cordic_state_t;

  cordic_state_t      state;
  logic [RW-1:0]      r;
  logic [RW-1:0]      m;
  logic [4:0]         cnt;
  logic               neg;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [34:0] z;

  logic signed [RW-1:0] ang_wide;
  logic signed [34:0]   rr;
  logic signed [34:0]   wrapped;
  logic signed [34:0]   atan_ext;

  always_comb begin
    ang_wide = RW'(angle) <<< (30 - FRAC_BITS);
    rr       = $signed(r[34:0]);
    wrapped  = (rr > Q30_PI) ? rr - Q30_TWO_PI : rr;
    atan_ext = $signed({5'b0, atan_q30(cnt)});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            r     <= RW'(ang_wide) + RED_OFS;
            m     <= MOD_TOP;
            cnt   <= 5'(KMAX);
            state <= C_RED;
          end
        end
        C_RED: begin
          // one conditional subtract of 2*pi<<k per cycle
          if (r >= m) begin
            r <= r - m;
          end
          m   <= m >> 1;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            state <= C_FOLD;
          end
        end
        C_FOLD: begin
          x   <= Q30_GAIN;
          y   <= '0;
          cnt <= '0;
          if (wrapped > Q30_HALF_PI) begin
            z   <= wrapped - Q30_PI;
            neg <= 1'b1;
          end else if (wrapped < -Q30_HALF_PI) begin
            z   <= wrapped + Q30_PI;
            neg <= 1'b1;
          end else begin
            z   <= wrapped;
            neg <= 1'b0;
          end
          state <= C_ROT;
        end
        C_ROT: begin
          if (z >= 0) begin
            x <= x - (y >>> cnt);
            y <= y + (x >>> cnt);
            z <= z - atan_ext;
          end else begin
            x <= x + (y >>> cnt);
            y <= y - (x >>> cnt);
            z <= z + atan_ext;
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'(NS - 1)) begin
            done  <= 1'b1;
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  // x and y hold the last rotation once done pulses
  assign sin_q30 = neg ? -y[31:0] : y[31:0];
  assign cos_q30 = neg ? -x[31:0] : x[31:0];

  a_done_from_rot: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == C_ROT))
    else $error("cordic done outside rotation");

endmodule
